FILE: sv/lfb_pkg.sv
package lfb_pkg;

	localparam int KindW = 3;
	localparam int ByteW = 8;
	localparam int IdW = 6;

	localparam logic [KindW-1:0] KIND_BREAK = 3'd0;
	localparam logic [KindW-1:0] KIND_DELIM = 3'd1;
	localparam logic [KindW-1:0] KIND_SYNC = 3'd2;
	localparam logic [KindW-1:0] KIND_PID = 3'd3;
	localparam logic [KindW-1:0] KIND_DATA = 3'd4;
	localparam logic [KindW-1:0] KIND_CKSUM = 3'd5;

	localparam logic [ByteW-1:0] BYTE_BREAK = 8'h00;
	localparam logic [ByteW-1:0] BYTE_DELIM = 8'h01;
	localparam logic [ByteW-1:0] BYTE_SYNC = 8'h55;

	typedef struct packed {
		logic start;
		logic last;
		logic [ByteW-1:0] pid;
		logic [ByteW-1:0] data;
		logic [ByteW-1:0] cksum;
	} job_t;

	function automatic logic [ByteW-1:0] protect_id(input logic [IdW-1:0] id);
		logic p0;
		logic p1;
		p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
		p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
		return {p1, p0, id};
	endfunction

	function automatic logic [ByteW-1:0] add_carry(input logic [ByteW-1:0] a,
			input logic [ByteW-1:0] b);
		logic [ByteW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[ByteW-1:0] + {{(ByteW-1){1'b0}}, s[ByteW]};
	endfunction

endpackage

FILE: sv/lfb_front.sv
module lfb_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [lfb_pkg::IdW-1:0] frame_id,
	input logic [lfb_pkg::ByteW-1:0] data_byte,
	input logic end_of_frame,
	output logic push,
	output lfb_pkg::job_t job,
	input logic full
);
	import lfb_pkg::*;

	logic in_frame_q;
	logic [ByteW-1:0] sum_q;
	logic [ByteW-1:0] pid;
	logic [ByteW-1:0] base;
	logic [ByteW-1:0] sum_next;

	assign in_ready = ~full;
	assign push = in_valid & ~full;

	assign pid = protect_id(frame_id);
	assign base = in_frame_q ? sum_q : pid;
	assign sum_next = add_carry(base, data_byte);

	always_comb begin
		job.start = ~in_frame_q;
		job.last = end_of_frame;
		job.pid = pid;
		job.data = data_byte;
		job.cksum = ~sum_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			sum_q <= '0;
		end else if (push) begin
			in_frame_q <= ~end_of_frame;
			sum_q <= end_of_frame ? '0 : sum_next;
		end
	end

endmodule

FILE: sv/lfb_queue.sv
module lfb_queue #(
	parameter int DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input lfb_pkg::job_t push_job,
	output logic full,
	input logic pop,
	output lfb_pkg::job_t head,
	output logic empty
);
	import lfb_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	job_t mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic do_pop;

	assign full = (count_q == FullCnt);
	assign empty = (count_q == '0);
	assign head = mem_q[rd_ptr_q];
	assign do_pop = pop & ~empty;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: sv/lfb_back.sv
module lfb_back (
	input logic clk,
	input logic arst_n,
	input lfb_pkg::job_t head,
	input logic empty,
	output logic pop,
	output logic out_valid,
	input logic out_ready,
	output logic [lfb_pkg::ByteW-1:0] out_byte,
	output logic [lfb_pkg::KindW-1:0] byte_kind,
	output logic last_of_run
);
	import lfb_pkg::*;

	logic mid_q;
	logic [KindW-1:0] kind_q;
	logic valid_q;
	logic [ByteW-1:0] byte_q;
	logic [KindW-1:0] okind_q;
	logic last_q;

	logic advance;
	logic [KindW-1:0] next_kind;
	logic [ByteW-1:0] next_byte;
	logic next_last;

	assign advance = ~empty & (~valid_q | out_ready);
	assign next_kind = mid_q ? kind_q : (head.start ? KIND_BREAK : KIND_DATA);

	always_comb begin
		next_last = 1'b0;
		unique case (next_kind)
			KIND_BREAK: next_byte = BYTE_BREAK;
			KIND_DELIM: next_byte = BYTE_DELIM;
			KIND_SYNC: next_byte = BYTE_SYNC;
			KIND_PID: next_byte = head.pid;
			KIND_DATA: begin
				next_byte = head.data;
				next_last = ~head.last;
			end
			KIND_CKSUM: begin
				next_byte = head.cksum;
				next_last = 1'b1;
			end
			default: next_byte = '0;
		endcase
	end

	assign pop = advance & next_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q <= 1'b0;
			kind_q <= KIND_BREAK;
			valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_q <= 1'b1;
				mid_q <= ~next_last;
				kind_q <= next_kind + 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q <= next_byte;
			okind_q <= next_kind;
			last_q <= next_last;
		end
	end

	assign out_valid = valid_q;
	assign out_byte = byte_q;
	assign byte_kind = okind_q;
	assign last_of_run = last_q;

endmodule

FILE: sv/lin_frame_builder.sv
// channel  dir  tdata                              tuser           tlast
// s        in   [5:0] frame_id, [13:6] data_byte   -               end_of_frame
// m        out  [7:0] out_byte                     [2:0] byte_kind last_of_run
//
// each payload word yields one data byte; a frame's first word adds break,
// delimiter, sync and protected id before it, its last word the checksum.
// the back sequencer emits one byte per cycle into the output register while
// a job waits and the output is not stalled; the queue lets the front take
// words while it drains. arst_n clears frame state, queue and output valid.
module lin_frame_builder #(
	parameter int QUEUE_DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [15:0] s_tdata,  // frame_id, data_byte, zero fill
	input logic s_tlast,
	output logic m_tvalid,
	input logic m_tready,
	output logic [7:0] m_tdata,  // out_byte
	output logic [2:0] m_tuser,  // byte_kind
	output logic m_tlast
);
	import lfb_pkg::*;

	job_t push_job;
	job_t head;
	logic push;
	logic full;
	logic pop;
	logic empty;

	lfb_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.frame_id(s_tdata[5:0]),
		.data_byte(s_tdata[13:6]),
		.end_of_frame(s_tlast),
		.push(push),
		.job(push_job),
		.full(full)
	);

	lfb_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.full(full),
		.pop(pop),
		.head(head),
		.empty(empty)
	);

	lfb_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.empty(empty),
		.pop(pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_byte(m_tdata),
		.byte_kind(m_tuser),
		.last_of_run(m_tlast)
	);

endmodule

FILE: dv/lin_frame_builder_tb.sv
`timescale 1ns / 1ps

module lin_frame_builder_tb;
	import lfb_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_WORDS = 280;

	typedef struct packed {
		logic [7:0] value;
		logic [2:0] kind;
		logic tail;
	} frame_byte_t;

	class lin_frame_sb;
		bit in_frame;
		logic [7:0] sum;
		frame_byte_t expected_q[$];
		int errors;
		int checked;

		function logic [7:0] pid_of(logic [5:0] id);
			logic p0;
			logic p1;
			p0 = ^(id & 6'b010111);
			p1 = ~^(id & 6'b111010);
			return {p1, p0, id};
		endfunction

		function logic [7:0] fold_add(logic [7:0] a, logic [7:0] b);
			logic [8:0] s;
			s = a + b;
			return s[7:0] + s[8];
		endfunction

		function void push(logic [7:0] value, logic [2:0] kind);
			frame_byte_t fb;
			fb.value = value;
			fb.kind = kind;
			fb.tail = 1'b0;
			expected_q.push_back(fb);
		endfunction

		// header on the first word of a frame, checksum on the last
		function void note_word(logic [5:0] id, logic [7:0] data, bit eof);
			logic [7:0] pid;
			if (!in_frame) begin
				pid = pid_of(id);
				push(BYTE_BREAK, KIND_BREAK);
				push(BYTE_DELIM, KIND_DELIM);
				push(BYTE_SYNC, KIND_SYNC);
				push(pid, KIND_PID);
				sum = pid;
				in_frame = 1'b1;
			end
			push(data, KIND_DATA);
			sum = fold_add(sum, data);
			if (eof) begin
				push(~sum, KIND_CKSUM);
				in_frame = 1'b0;
				sum = 8'h00;
			end
			expected_q[expected_q.size()-1].tail = 1'b1;
		endfunction

		function void check_byte(logic [7:0] value, logic [2:0] kind, logic tail);
			frame_byte_t exp_fb;
			checked++;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected byte %h kind %0d last %b", $time, value, kind, tail);
				return;
			end
			exp_fb = expected_q.pop_front();
			if (exp_fb.value !== value || exp_fb.kind !== kind || exp_fb.tail !== tail) begin
				errors++;
				if (errors <= 10)
					$display("%0t: expected byte %h kind %0d last %b, got %h kind %0d last %b",
						$time, exp_fb.value, exp_fb.kind, exp_fb.tail, value, kind, tail);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = 16'h0000;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [2:0] m_tuser;
	logic m_tlast;

	lin_frame_sb sb = new;
	bit steady = 1'b0;
	int rx_hold = 0;
	int idle_cycles = 0;
	int words_sent = 0;
	int frames_sent = 0;
	int single_frames = 0;

	lin_frame_builder dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	function automatic int gap_len();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	task automatic drive_word(int gap, logic [5:0] id, logic [7:0] data, bit eof);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			s_tdata = {2'b00, 14'($urandom)};
			s_tlast = 1'($urandom);
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {2'b00, data, id};
		s_tlast = eof;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_word(id, data, eof);
		words_sent++;
		if (eof)
			frames_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// receiver stalls
	always @(negedge clk) begin
		if (steady) begin
			m_tready = 1'b1;
			rx_hold = 0;
		end else if (rx_hold > 0) begin
			m_tready = 1'b0;
			rx_hold--;
		end else begin
			m_tready = 1'b1;
			if ($urandom_range(0, 2) == 0)
				rx_hold = gap_len();
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_byte(m_tdata, m_tuser, m_tlast);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		int len;
		int rand_words;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// single-word frames at the id and data extremes
		drive_word(gap_len(), 6'h00, 8'h00, 1'b1);
		drive_word(gap_len(), 6'h3f, 8'hff, 1'b1);
		// carry folding, id changes inside the frame are ignored
		drive_word(gap_len(), 6'h2a, 8'hff, 1'b0);
		drive_word(gap_len(), 6'h15, 8'hff, 1'b0);
		drive_word(gap_len(), 6'h3f, 8'hff, 1'b0);
		drive_word(gap_len(), 6'h00, 8'h01, 1'b1);
		drive_word(gap_len(), 6'h15, 8'h80, 1'b0);
		drive_word(gap_len(), 6'h2a, 8'h7f, 1'b0);
		drive_word(gap_len(), 6'h00, 8'h00, 1'b1);
		// one id bit at a time for the parity bits
		for (int b = 0; b < 6; b++)
			drive_word(gap_len(), 6'(1 << b), (b % 2) ? 8'haa : 8'h55, 1'b1);
		single_frames = 8;

		// hold off until the block has drained
		drain();

		rand_words = 0;
		while (rand_words < RANDOM_WORDS) begin
			if ($urandom_range(0, 9) == 0)
				len = $urandom_range(9, 24);
			else
				len = $urandom_range(1, 6);
			if (len == 1)
				single_frames++;
			steady = ($urandom_range(0, 4) == 0);
			for (int i = 0; i < len; i++)
				drive_word(gap_len(), 6'($urandom), 8'($urandom), i == len - 1);
			rand_words += len;
		end
		@(negedge clk);
		s_tvalid = 1'b0;
		s_tlast = 1'b0;
		steady = 1'b0;

		drain();
		repeat (20) @(posedge clk);

		$display("sent %0d words in %0d frames (%0d single-word), checked %0d bytes",
			words_sent, frames_sent, single_frames, sb.checked);
		$display("mismatches: %0d", sb.errors);
		if (sb.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
